/* sv/assert_macros.svh */
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define RTPHP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtphp assertion failed");

// next-cycle implication
`define RTPHP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtphp assertion failed");

`endif

/* sv/rtphp_pkg.sv */
// types, constants and status codes of the rtp header parser
package rtphp_pkg;

   localparam int MAX_PACKET_BYTES = 4096;
   // byte counter holds up to MAX_PACKET_BYTES + 1
   localparam int IDX_W            = $clog2(MAX_PACKET_BYTES + 2);
   // header end reaches 12 + 60 + 4 + 4 * 65535
   localparam int HEND_W           = 19;
   localparam int FIXED_HDR_BYTES  = 12;
   localparam int OUT_POS_W        = 13;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ZRTP_ACCEPT = 2'd0;

   localparam logic [1:0] RTP_VERSION  = 2'd2;
   localparam logic [1:0] ZRTP_VERSION = 2'd0;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SHORT,
      ST_BAD_VERSION,
      ST_ZRTP_IGNORED,
      ST_CSRC_OVERRUN,
      ST_EXT_OVERRUN,
      ST_BAD_PADDING,
      ST_TOO_LONG
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic                 marker;
      logic [6:0]           payload_type;
      logic [15:0]          seq_num;
      logic [31:0]          time_stamp;
      logic [31:0]          sync_source;
      logic [3:0]           csrc_count;
      logic                 ext_present;
      logic [15:0]          ext_words;
      logic [OUT_POS_W-1:0] payload_offset;
      logic [OUT_POS_W-1:0] payload_size;
      logic [7:0]           pad_size;
   } rsp_type;

   // packet state captured at the last byte, handed to the evaluation stage
   typedef struct packed {
      logic [IDX_W-1:0]  byte_count;
      logic [7:0]        first_hdr;
      logic [7:0]        second_hdr;
      logic [15:0]       seq;
      logic [31:0]       stamp;
      logic [31:0]       ssrc;
      logic [15:0]       ext_len;
      logic [HEND_W-1:0] header_end;
      logic [7:0]        last_data;
   } snap_type;

endpackage

/* sv/rtphp_capture.sv */
// byte capture: header field shift registers, byte counter and end-of-packet snapshot
module rtphp_capture (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  rtphp_pkg::req_type req_data,
   output logic               req_stall,
   input  logic               eval_ready,
   output logic               snap_valid,
   output rtphp_pkg::snap_type snap
);
   import rtphp_pkg::*;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [7:0]        first_ff, first_in;
   logic [7:0]        second_ff, second_in;
   logic [15:0]       seq_ff, seq_in;
   logic [31:0]       stamp_ff, stamp_in;
   logic [31:0]       ssrc_ff, ssrc_in;
   logic [15:0]       ext_len_ff, ext_len_in;
   logic [HEND_W-1:0] hend_ff, hend_in;
   logic              snap_valid_ff, snap_valid_in;
   snap_type          snap_ff, snap_in;

   logic              accept;
   logic              pkt_done;
   logic [HEND_W-1:0] pos;
   logic [HEND_W-1:0] csrc_end;
   logic [15:0]       ext_len_next;
   logic [7:0]        b;

   // hold off new bytes only while the snapshot cannot move on
   assign req_stall = snap_valid_ff && !eval_ready;
   assign accept    = req_valid && !req_stall;
   assign pkt_done  = accept && req_data.last_byte;
   assign b         = req_data.data_byte;

   // header field capture by byte position
   always_comb begin
      idx_in       = idx_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      seq_in       = seq_ff;
      stamp_in     = stamp_ff;
      ssrc_in      = ssrc_ff;
      ext_len_in   = ext_len_ff;
      hend_in      = hend_ff;
      pos          = HEND_W'(idx_ff);
      csrc_end     = HEND_W'(FIXED_HDR_BYTES) + HEND_W'({first_ff[3:0], 2'b00});
      ext_len_next = {ext_len_ff[7:0], b};
      if (accept && (pos <= HEND_W'(MAX_PACKET_BYTES))) begin
         if (pos == HEND_W'(0)) begin
            first_in = b;
         end else if (pos == HEND_W'(1)) begin
            second_in = b;
         end else if (pos < HEND_W'(4)) begin
            seq_in = {seq_ff[7:0], b};
         end else if (pos < HEND_W'(8)) begin
            stamp_in = {stamp_ff[23:0], b};
         end else if (pos < HEND_W'(FIXED_HDR_BYTES)) begin
            ssrc_in = {ssrc_ff[23:0], b};
            if (pos == HEND_W'(FIXED_HDR_BYTES - 1)) begin
               hend_in = csrc_end + (first_ff[4] ? HEND_W'(4) : HEND_W'(0));
            end
         end else if (first_ff[4] && ((pos == csrc_end + HEND_W'(2)) ||
                                      (pos == csrc_end + HEND_W'(3)))) begin
            ext_len_in = ext_len_next;
            if (pos == csrc_end + HEND_W'(3)) begin
               hend_in = csrc_end + HEND_W'(4) + HEND_W'({ext_len_next, 2'b00});
            end
         end
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // snapshot contents and handover
   always_comb begin
      snap_in.byte_count = idx_in;
      snap_in.first_hdr  = first_in;
      snap_in.second_hdr = second_in;
      snap_in.seq        = seq_in;
      snap_in.stamp      = stamp_in;
      snap_in.ssrc       = ssrc_in;
      snap_in.ext_len    = ext_len_in;
      snap_in.header_end = hend_in;
      snap_in.last_data  = b;
      snap_valid_in      = snap_valid_ff;
      if (pkt_done) begin
         snap_valid_in = 1'b1;
      end else if (snap_valid_ff && eval_ready) begin
         snap_valid_in = 1'b0;
      end
   end

   // packet state, cleared on reset and after every last byte
   always_ff @(posedge clock) begin
      if (reset || pkt_done) begin
         idx_ff     <= '0;
         first_ff   <= '0;
         second_ff  <= '0;
         seq_ff     <= '0;
         stamp_ff   <= '0;
         ssrc_ff    <= '0;
         ext_len_ff <= '0;
         hend_ff    <= HEND_W'(FIXED_HDR_BYTES);
      end else begin
         idx_ff     <= idx_in;
         first_ff   <= first_in;
         second_ff  <= second_in;
         seq_ff     <= seq_in;
         stamp_ff   <= stamp_in;
         ssrc_ff    <= ssrc_in;
         ext_len_ff <= ext_len_in;
         hend_ff    <= hend_in;
      end
   end

   // snapshot register
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
      end
      if (pkt_done) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

/* sv/rtphp_eval.sv */
// packet evaluation: status, payload bounds and the result register
module rtphp_eval (
   input  logic                clock,
   input  logic                reset,
   input  logic                snap_valid,
   input  rtphp_pkg::snap_type snap,
   input  logic                zrtp_accept,
   output logic                eval_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rtphp_pkg::rsp_type  rsp_data
);
   import rtphp_pkg::*;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              take;
   logic [HEND_W-1:0] n;
   logic [HEND_W-1:0] csrc_end;
   logic [HEND_W-1:0] rem;
   logic [HEND_W-1:0] plen;
   logic [HEND_W-1:0] pad_ext;
   logic [1:0]        ver;
   logic              has_pad;
   logic              ext;
   logic              ext_seen;
   status_type        status;

   assign eval_ready = !rsp_valid_ff || !rsp_stall;
   assign take       = snap_valid && eval_ready;

   // header decode and length checks
   always_comb begin
      n        = HEND_W'(snap.byte_count);
      ver      = snap.first_hdr[7:6];
      has_pad  = snap.first_hdr[5];
      ext      = snap.first_hdr[4];
      csrc_end = HEND_W'(FIXED_HDR_BYTES) + HEND_W'({snap.first_hdr[3:0], 2'b00});
      ext_seen = ext && (n >= csrc_end + HEND_W'(4));
      rem      = n - snap.header_end;
      pad_ext  = has_pad ? HEND_W'(snap.last_data) : '0;
      plen     = rem - pad_ext;

      if (n > HEND_W'(MAX_PACKET_BYTES)) begin
         status = ST_TOO_LONG;
      end else if (ver != RTP_VERSION) begin
         status = (ver == ZRTP_VERSION && zrtp_accept) ? ST_ZRTP_IGNORED : ST_BAD_VERSION;
      end else if (n < csrc_end) begin
         status = ST_CSRC_OVERRUN;
      end else if (ext && (!ext_seen || n < snap.header_end)) begin
         status = ST_EXT_OVERRUN;
      end else if (has_pad && (snap.last_data == 8'd0 || rem <= pad_ext)) begin
         status = ST_BAD_PADDING;
      end else begin
         status = ST_OK;
      end

      rsp_in.status         = status;
      rsp_in.marker         = snap.second_hdr[7];
      rsp_in.payload_type   = snap.second_hdr[6:0];
      rsp_in.seq_num        = snap.seq;
      rsp_in.time_stamp     = snap.stamp;
      rsp_in.sync_source    = snap.ssrc;
      rsp_in.csrc_count     = snap.first_hdr[3:0];
      rsp_in.ext_present    = ext;
      rsp_in.ext_words      = ext_seen ? snap.ext_len : 16'd0;
      rsp_in.payload_offset = '0;
      rsp_in.payload_size   = '0;
      rsp_in.pad_size       = '0;
      if (status == ST_OK) begin
         rsp_in.payload_offset = snap.header_end[OUT_POS_W-1:0];
         rsp_in.payload_size   = plen[OUT_POS_W-1:0];
         rsp_in.pad_size       = pad_ext[7:0];
      end

      // short packet reports nothing but its status
      if (n < HEND_W'(FIXED_HDR_BYTES)) begin
         rsp_in        = '0;
         rsp_in.status = ST_SHORT;
      end
   end

   // result valid tracking
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sv/rtp_header_parser_unit.sv */
// top level of the rtp header parser: csr port, byte capture and evaluation
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_type: data_byte, last_byte
//   rsp_      out        rsp_valid/rsp_stall  rsp_type: status and header fields
//   csr_      in         apb psel/penable     zrtp_accept at address 0
//
// one packet byte is taken every cycle while req_stall is low; the byte counter and
// field shift registers update in the capture stage at the same edge.
// the result for a packet passes through the snapshot register and then the
// result register after its last byte is taken.
// reset is synchronous and clears the packet state and both valid flags.
// req_stall rises only when the snapshot and the result register are both
// full and rsp_stall is high; bytes that are not last still wait then.
module rtp_header_parser_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rtphp_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rtphp_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rtphp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rtphp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rtphp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import rtphp_pkg::*;

   logic     zrtp_accept_ff, zrtp_accept_in;
   logic     csr_write;
   logic     eval_ready;
   logic     snap_valid;
   snap_type snap;

   // csr write decode
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      zrtp_accept_in = zrtp_accept_ff;
      if (csr_write && csr_paddr == CSR_ZRTP_ACCEPT) begin
         zrtp_accept_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zrtp_accept_ff <= 1'b0;
      end else begin
         zrtp_accept_ff <= zrtp_accept_in;
      end
   end

   // csr read data
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_ZRTP_ACCEPT) begin
         csr_prdata = CSR_DATA_W'(zrtp_accept_ff);
      end
   end

   // byte capture stage
   rtphp_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .eval_ready (eval_ready),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   // evaluation stage and result register
   rtphp_eval u_eval (
      .clock       (clock),
      .reset       (reset),
      .snap_valid  (snap_valid),
      .snap        (snap),
      .zrtp_accept (zrtp_accept_ff),
      .eval_ready  (eval_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

/* sv/rtphp_checker.sv */
// port-level checker for the rtp header parser, bound to the top level
`include "assert_macros.svh"

module rtphp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input rtphp_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input rtphp_pkg::rsp_type rsp_data
);
   import rtphp_pkg::*;

   logic rsp_waiting;
   logic req_last_taken;
   logic rsp_failed;
   logic no_bounds;
   logic rsp_short;
   logic no_fields;

   assign rsp_waiting    = rsp_valid && rsp_stall;
   assign req_last_taken = req_valid && !req_stall && req_data.last_byte;
   assign rsp_failed     = rsp_valid && rsp_data.status != ST_OK;
   assign no_bounds      = rsp_data.payload_offset == '0 && rsp_data.payload_size == '0 &&
                           rsp_data.pad_size == '0;
   assign rsp_short      = rsp_valid && rsp_data.status == ST_SHORT;
   assign no_fields      = rsp_data.seq_num == '0 && rsp_data.time_stamp == '0 &&
                           rsp_data.csrc_count == '0;

   // a stalled result holds its value
   `RTPHP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waiting, rsp_valid && $stable(rsp_data))

   // a new result follows a last byte taken before it, by way of the snapshot register
   `RTPHP_ASSERT_IMPLY(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_last_taken, 2))

   // the request side waits only behind a stalled result
   `RTPHP_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_waiting)

   // failed packets report no payload bounds
   `RTPHP_ASSERT_IMPLY(a_fail_bounds, clock, reset, rsp_failed, no_bounds)

   // short packets report no header fields
   `RTPHP_ASSERT_IMPLY(a_short_zero, clock, reset, rsp_short, no_fields)

endmodule

bind rtp_header_parser_unit rtphp_checker u_rtphp_checker (.*);
